// ----- design/tcw_pkg.sv -----
// Package for the text console character writer.
// Holds field widths, character codes, request and class types, queue sizing.
// No dependencies.
package tcw_pkg;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_PRINT,
    CLS_BS,
    CLS_TAB,
    CLS_CR,
    CLS_LF
  } cls_e;

  typedef struct packed {
    req_e              kind;
    cls_e              cls;
    logic [CHAR_W-1:0] code;
    logic [IDX_W-1:0]  idx;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

endpackage

// ----- design/tcw_stream_if.sv -----
// Request and response channel interfaces of the console writer.
// Depends on tcw_pkg for field widths.
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input req_type, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_loc;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  modport source (output valid, output cursor_loc, output cell_data, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_loc, input cell_data, input scrolled,
                  output ready);
endinterface

// ----- design/text_console_char_writer.sv -----
// Text console character writer, top level.
// Depends on tcw_pkg, tcw_stream_if, tcw_ram, tcw_front and tcw_back.
//
// Requests arrive on req_i (put character, clear screen, read cell) and each
// produces exactly one response on rsp_o with the cursor position, the cell
// read back (zero unless a read) and a scroll flag. The attribute register is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. A two-entry queue
// sits between the request classifier and the executor, so requests are taken
// while the executor is busy or a response waits. In the executor, a put without
// scroll, an ignored type or an out-of-range read is answered from the idle state;
// a read in range waits on the registered frame store read; a clear writes one
// cell per cycle; a put that scrolls streams the row move from the store's read
// port to its write port, waits while the last moved cell is written, then blanks
// the last row. Every response is held in a register.
// Reset homes the cursor and sets the attribute to 0x0F; the frame store is
// not swept and holds garbage until the first clear. A stalled response holds
// in its register; the queue then fills and req_i.ready drops.
module text_console_char_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_req_if.sink           req_i,
  tcw_rsp_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [ATTR_W-1:0] attr_q;
  qhead_t            head;
  logic              pop;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .attr_i  (attr_q),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .rsp_o   (rsp_o)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("executor popped an empty queue");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid && !pop |=> head.valid)
    else $error("queued operation lost before execution");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (waddr <= ADDR_W'(CELLS - 1)))
    else $error("frame store write beyond last cell");

endmodule

// ----- design/tcw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/tcw_front.sv -----
// Front end: accepts request transactions, classifies them, queues them.
// Depends on tcw_pkg and tcw_req_if.
module tcw_front import tcw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  tcw_req_if.sink req_i,
  output qhead_t head_o,
  input  logic  pop_i
);

  op_t                op_in;
  op_t                ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push, pop;

  always_comb begin
    op_in.kind = req_e'(req_i.req_type);
    op_in.code = req_i.char_code;
    op_in.idx  = req_i.cell_index;
    if (req_i.char_code >= CH_SPACE && req_i.char_code <= CH_LAST) begin
      op_in.cls = CLS_PRINT;
    end else if (req_i.char_code == CH_BS) begin
      op_in.cls = CLS_BS;
    end else if (req_i.char_code == CH_TAB) begin
      op_in.cls = CLS_TAB;
    end else if (req_i.char_code == CH_CR) begin
      op_in.cls = CLS_CR;
    end else if (req_i.char_code == CH_LF) begin
      op_in.cls = CLS_LF;
    end else begin
      op_in.cls = CLS_IGNORE;
    end
  end

  assign req_i.ready  = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push         = req_i.valid && req_i.ready;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = ent_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + Q_PTR_W'(1);
    end
    if (pop) begin
      rp_d = (rp_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= op_in;
    end
  end

endmodule

// ----- design/tcw_back.sv -----
// Back end: executes queued operations on the cursor and the frame store,
// sequences clear and scroll sweeps, and holds the response register.
// Depends on tcw_pkg and tcw_rsp_if; drives the ports of one tcw_ram.
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qhead_t            head_i,
  output logic              pop_o,
  input  logic [ATTR_W-1:0] attr_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [CELL_W-1:0] wdata_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [CELL_W-1:0] rdata_i,
  tcw_rsp_if.source         rsp_o
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int WIDE_W = ADDR_W + POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              mv_vld_q, mv_vld_d;
  logic [ADDR_W-1:0] mv_addr_q, mv_addr_d;

  logic              out_vld_q, out_vld_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CELL_W-1:0] data_q, data_d;
  logic              scr_q, scr_d;

  logic [COLX_W-1:0] colx;
  logic [ROWX_W-1:0] rowx;
  logic              out_free;
  logic [WIDE_W-1:0] wide_idx;
  logic              idx_ok;
  logic [CELL_W-1:0] blank;

  function automatic logic [POS_W-1:0] cur_pos(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] p;
    logic [WIDE_W-1:0] w;
    p = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    w = {{POS_W{1'b0}}, p};
    return w[POS_W-1:0];
  endfunction

  assign blank    = {attr_i, CH_SPACE};
  assign out_free = !out_vld_q || rsp_o.ready;
  assign wide_idx = {{ADDR_W{1'b0}}, head_i.op.idx};
  assign idx_ok   = wide_idx < WIDE_W'(CELLS);

  always_comb begin
    colx = COLX_W'(col_q);
    rowx = ROWX_W'(row_q);
    case (head_i.op.cls)
      CLS_BS: begin
        if (col_q != '0) begin
          colx = COLX_W'(col_q) - COLX_W'(1);
        end
      end
      CLS_TAB: begin
        colx = (COLX_W'(col_q) + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
      end
      CLS_CR: begin
        colx = '0;
      end
      CLS_LF: begin
        colx = '0;
        rowx = ROWX_W'(row_q) + ROWX_W'(1);
      end
      CLS_PRINT: begin
        colx = COLX_W'(col_q) + COLX_W'(1);
      end
      default: begin
      end
    endcase
    if (colx >= COLX_W'(COLUMNS)) begin
      colx = '0;
      rowx = rowx + ROWX_W'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    mv_vld_d  = 1'b0;
    mv_addr_d = cnt_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    pos_d     = pos_q;
    data_d    = data_q;
    scr_d     = scr_q;
    pop_o     = 1'b0;
    we_o      = 1'b0;
    waddr_o   = cnt_q;
    wdata_o   = blank;
    raddr_o   = wide_idx[ADDR_W-1:0];

    if (mv_vld_q) begin
      we_o    = 1'b1;
      waddr_o = mv_addr_q;
      wdata_o = rdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          case (head_i.op.kind)
            REQ_PUT: begin
              if (head_i.op.cls == CLS_PRINT) begin
                we_o    = 1'b1;
                waddr_o = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
                wdata_o = {attr_i, head_i.op.code};
              end
              col_d = colx[COL_W-1:0];
              if (rowx == ROWX_W'(ROWS)) begin
                row_d   = ROW_W'(ROWS - 1);
                cnt_d   = '0;
                state_d = S_MOVE;
              end else begin
                row_d     = rowx[ROW_W-1:0];
                out_vld_d = 1'b1;
                pos_d     = cur_pos(rowx[ROW_W-1:0], colx[COL_W-1:0]);
                data_d    = '0;
                scr_d     = 1'b0;
              end
            end
            REQ_CLEAR: begin
              cnt_d   = '0;
              state_d = S_FILL;
            end
            REQ_READ: begin
              if (idx_ok) begin
                state_d = S_RD;
              end else begin
                out_vld_d = 1'b1;
                pos_d     = cur_pos(row_q, col_q);
                data_d    = '0;
                scr_d     = 1'b0;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              pos_d     = cur_pos(row_q, col_q);
              data_d    = '0;
              scr_d     = 1'b0;
            end
          endcase
        end
      end
      S_RD: begin
        out_vld_d = 1'b1;
        pos_d     = cur_pos(row_q, col_q);
        data_d    = rdata_i;
        scr_d     = 1'b0;
        state_d   = S_IDLE;
      end
      S_FILL: begin
        we_o    = 1'b1;
        waddr_o = cnt_q;
        wdata_o = blank;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          col_d     = '0;
          row_d     = '0;
          out_vld_d = 1'b1;
          pos_d     = '0;
          data_d    = '0;
          scr_d     = 1'b0;
          state_d   = S_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_MOVE: begin
        raddr_o   = cnt_q + ADDR_W'(COLUMNS);
        mv_vld_d  = 1'b1;
        mv_addr_d = cnt_q;
        if (cnt_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
          cnt_d   = ADDR_W'(CELLS - COLUMNS);
          state_d = S_BLANK;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_BLANK: begin
        if (!mv_vld_q) begin
          we_o    = 1'b1;
          waddr_o = cnt_q;
          wdata_o = blank;
          if (cnt_q == ADDR_W'(CELLS - 1)) begin
            out_vld_d = 1'b1;
            pos_d     = cur_pos(row_q, col_q);
            data_d    = '0;
            scr_d     = 1'b1;
            state_d   = S_IDLE;
          end else begin
            cnt_d = cnt_q + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      mv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      mv_vld_q  <= mv_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_addr_q <= mv_addr_d;
    pos_q     <= pos_d;
    data_q    <= data_d;
    scr_q     <= scr_d;
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.cursor_loc = pos_q;
  assign rsp_o.cell_data  = data_q;
  assign rsp_o.scrolled   = scr_q;

endmodule

// ----- tb/text_console_char_writer_tb.sv -----
// Testbench for text_console_char_writer: directed and random put, clear and read
// transactions with random idling, checked against a screen mirror held in a class.
// Depends on tcw_pkg, tcw_stream_if and the design sources.
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int CELLS       = DEF_ROWS * DEF_COLUMNS;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    logic [POS_W-1:0]  cursor_loc;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_status_t;

  class screen_mirror;
    logic [CELL_W-1:0] cells [CELLS];
    int                col;
    int                row;
    logic [ATTR_W-1:0] attr;
    console_status_t   awaited[$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      col        = 0;
      row        = 0;
      attr       = ATTR_RESET;
      mismatches = 0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function void take_request(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                               logic [IDX_W-1:0] idx);
      console_status_t st;
      st.cell_data = '0;
      st.scrolled  = 1'b0;
      case (req_e'(kind))
        REQ_PUT: begin
          if (ch == CH_BS) begin
            if (col != 0) col--;
          end else if (ch == CH_TAB) begin
            col = (col / TAB_STEP + 1) * TAB_STEP;
          end else if (ch == CH_CR) begin
            col = 0;
          end else if (ch == CH_LF) begin
            col = 0;
            row++;
          end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
            cells[row * DEF_COLUMNS + col] = {attr, ch};
            col++;
          end
          if (col >= DEF_COLUMNS) begin
            col = 0;
            row++;
          end
          if (row >= DEF_ROWS) begin
            for (int i = 0; i < CELLS - DEF_COLUMNS; i++) cells[i] = cells[i + DEF_COLUMNS];
            for (int i = CELLS - DEF_COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
            row         = DEF_ROWS - 1;
            st.scrolled = 1'b1;
          end
        end
        REQ_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CH_SPACE};
          col = 0;
          row = 0;
        end
        REQ_READ: begin
          if (idx < CELLS) st.cell_data = cells[idx];
        end
        default: ;
      endcase
      st.cursor_loc = POS_W'(row * DEF_COLUMNS + col);
      awaited.push_back(st);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
    endfunction

    function void check_response(logic [POS_W-1:0] pos, logic [CELL_W-1:0] data,
                                 logic scr);
      console_status_t st;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("response with no pending transaction: cursor_loc 0x%0h", pos);
        return;
      end
      st = awaited.pop_front();
      if (pos !== st.cursor_loc) report("cursor_loc", 32'(st.cursor_loc), 32'(pos));
      if (data !== st.cell_data) report("cell_data", 32'(st.cell_data), 32'(data));
      if (scr !== st.scrolled) report("scrolled", 32'(st.scrolled), 32'(scr));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_wdata_i;
  screen_mirror      mirror;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                snk_hold_left;
  int                cycle_count = 0;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();

  text_console_char_writer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) mirror.set_attribute(cfg_wdata_i);
      if (rsp_if.valid && rsp_if.ready)
        mirror.check_response(rsp_if.cursor_loc, rsp_if.cell_data, rsp_if.scrolled);
      if (req_if.valid && req_if.ready)
        mirror.take_request(req_if.req_type, req_if.char_code, req_if.cell_index);
    end
  end

  // hold off the response channel while a stall is pending, else idle at random
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (snk_hold_left > 0) begin
        rsp_if.ready = 1'b0;
        snk_hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_request(req_e kind, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = kind;
    req_if.char_code  = ch;
    req_if.cell_index = idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_text(int count);
    req_e              kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(999);
      ch   = CHAR_W'($urandom_range(255));
      idx  = IDX_W'($urandom_range(2047));
      if (pick < 3) begin
        kind = REQ_CLEAR;
      end else if (pick < 83) begin
        kind = REQ_READ;
        if ($urandom_range(19) != 0) idx = IDX_W'($urandom_range(CELLS - 1));
        else idx = IDX_W'($urandom_range(2047, CELLS));
      end else if (pick < 98) begin
        kind = REQ_NOP;
      end else begin
        kind = REQ_PUT;
        pick = $urandom_range(99);
        if (pick < 8) ch = CH_LF;
        else if (pick < 14) ch = CH_TAB;
        else if (pick < 19) ch = CH_BS;
        else if (pick < 22) ch = CH_CR;
        else if (pick < 25) ch = CHAR_W'($urandom_range(31));
        else if (pick < 29) ch = CHAR_W'($urandom_range(255, 128));
        else ch = CHAR_W'($urandom_range(CH_LAST, CH_SPACE));
      end
      send_request(kind, ch, idx);
    end
  endtask

  task automatic drain_responses();
    req_if.valid = 1'b0;
    while (mirror.awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    mirror            = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_PUT;
    req_if.char_code  = '0;
    req_if.cell_index = '0;
    src_idle_pct      = 31;
    snk_idle_pct      = 83;
    snk_hold_left     = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(REQ_CLEAR, 8'h00, '0);
    send_request(REQ_PUT, 8'h41, '0);
    send_request(REQ_PUT, CH_LAST, '0);
    send_request(REQ_PUT, CH_BS, '0);
    send_request(REQ_PUT, CH_SPACE, '0);
    send_request(REQ_PUT, CH_CR, '0);
    send_request(REQ_PUT, CH_BS, '0);
    send_request(REQ_PUT, 8'h00, '0);
    send_request(REQ_PUT, 8'h1F, '0);
    send_request(REQ_PUT, 8'h80, '0);
    send_request(REQ_PUT, 8'hFF, '1);
    send_request(REQ_READ, 8'h00, '0);
    send_request(REQ_READ, 8'hFF, IDX_W'(CELLS - 1));
    send_request(REQ_READ, 8'h00, IDX_W'(CELLS));
    send_request(REQ_READ, 8'h00, '1);
    send_request(REQ_NOP, 8'hFF, '1);
    send_request(REQ_PUT, CH_LF, '0);
    repeat (10) send_request(REQ_PUT, CH_TAB, '0);
    drain_responses();

    write_attribute(8'h00);
    send_random_text(620);
    drain_responses();

    write_attribute(8'hFF);
    src_idle_pct = 83;
    snk_idle_pct = 31;
    send_random_text(620);
    drain_responses();

    write_attribute(ATTR_W'($urandom_range(255)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random_text(300);
    snk_hold_left = 400;
    send_random_text(40);
    send_random_text(300);
    drain_responses();
    repeat (20) @(negedge clk_i);

    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- text_console_char_writer.f -----
design/tcw_pkg.sv
design/tcw_stream_if.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_char_writer.sv
tb/text_console_char_writer_tb.sv
